FILE: rtl/rbi_pkg.sv
// Shared constants and types for the ray/box intersection unit.
`default_nettype none
package rbi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 16;
    localparam int NUM_AXES        = 3;

    // axis codes for the chosen hit plane
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // per-item classification: an in-box flag plus one bit per axis for each other field
    typedef struct packed {
        logic       in_box;
        logic [2:0] ok;
        logic [2:0] over;
        logic [2:0] below;
        logic [2:0] dneg;
    } t_ctrl;

    localparam int CTRL_WIDTH = $bits(t_ctrl);

endpackage
`default_nettype wire

FILE: rtl/rbi_front.sv
// Front end: classifies each axis against the box and forms divider operands.
`default_nettype none
module rbi_front
    import rbi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [2:0][COORD_WIDTH-1:0] i_o,
    input  logic [2:0][COORD_WIDTH-1:0] i_h,
    input  logic [2:0][COORD_WIDTH-1:0] i_lo,
    input  logic [2:0][COORD_WIDTH-1:0] i_hi,
    output logic                        o_valid,
    output t_ctrl                       o_ctrl,
    output logic [2:0][COORD_WIDTH-1:0] o_o,
    output logic [2:0][COORD_WIDTH-1:0] o_lo,
    output logic [2:0][COORD_WIDTH-1:0] o_hi,
    output logic [2:0][COORD_WIDTH-1:0] o_dmag,
    output logic [2:0][COORD_WIDTH-1:0] o_nmag
);
    localparam int W  = COORD_WIDTH;
    localparam int CW = 2 * W + FRAC_BITS;

    logic [2:0]        n_below, n_above, n_ok, n_over, n_dneg;
    logic [2:0][W-1:0] n_dmag, n_nmag;
    t_ctrl             n_ctrl;

    logic              r_valid;
    t_ctrl             r_ctrl;
    logic [2:0][W-1:0] r_o, r_lo, r_hi, r_dmag, r_nmag;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        logic [W:0]    dlo, dho;
        logic [CW-1:0] lhs, rhs;
        assign n_below[g] = $signed(i_o[g]) < $signed(i_lo[g]);
        assign n_above[g] = !n_below[g] && ($signed(i_hi[g]) < $signed(i_o[g]));
        assign dlo = {i_lo[g][W-1], i_lo[g]} - {i_o[g][W-1], i_o[g]};
        assign dho = {i_o[g][W-1], i_o[g]} - {i_hi[g][W-1], i_hi[g]};
        assign n_nmag[g] = n_below[g] ? dlo[W-1:0] : dho[W-1:0];
        assign n_dneg[g] = i_h[g][W-1];
        assign n_dmag[g] = n_dneg[g] ? (~i_h[g] + 1'b1) : i_h[g];
        assign n_ok[g] = (n_below[g] | n_above[g]) && (n_dmag[g] != '0)
                         && (n_above[g] == n_dneg[g]);
        // quotient would reach 2^(W-1): saturate
        assign lhs = {{W{1'b0}}, n_nmag[g], {FRAC_BITS{1'b0}}};
        assign rhs = {{(FRAC_BITS + 1){1'b0}}, n_dmag[g], {(W - 1){1'b0}}};
        assign n_over[g] = lhs >= rhs;
    end

    always_comb begin
        n_ctrl.in_box = ~|(n_below | n_above);
        n_ctrl.ok     = n_ok;
        n_ctrl.over   = n_over;
        n_ctrl.below  = n_below;
        n_ctrl.dneg   = n_dneg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_ctrl <= n_ctrl;
            r_o    <= i_o;
            r_lo   <= i_lo;
            r_hi   <= i_hi;
            r_dmag <= n_dmag;
            r_nmag <= n_nmag;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_o     = r_o;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_dmag  = r_dmag;
    assign o_nmag  = r_nmag;
endmodule
`default_nettype wire

FILE: rtl/rbi_queue.sv
// Two-entry queue between front end and back end.
`default_nettype none
module rbi_queue
    import rbi_pkg::*;
#(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output logic [DATA_WIDTH-1:0] o_data
);
    logic [1:0]            r_count, n_count;
    logic [DATA_WIDTH-1:0] r_slot0, n_slot0, r_slot1, n_slot1;
    logic                  push, pop;

    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count == 2'd2;
    assign o_data  = r_slot0;
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        case ({push, pop})
            2'b10: begin
                if (r_count == 2'd0) n_slot0 = i_data;
                else                 n_slot1 = i_data;
                n_count = r_count + 2'd1;
            end
            2'b01: begin
                n_slot0 = r_slot1;
                n_count = r_count - 2'd1;
            end
            2'b11: begin
                if (r_count == 2'd1) begin
                    n_slot0 = i_data;
                end else begin
                    n_slot0 = r_slot1;
                    n_slot1 = i_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end
endmodule
`default_nettype wire

FILE: rtl/rbi_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
`default_nettype none
module rbi_div
    import rbi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic [COORD_WIDTH-1:0] i_num,
    input  logic [COORD_WIDTH-1:0] i_den,
    output logic [COORD_WIDTH-2:0] o_quo
);
    localparam int W  = COORD_WIDTH;
    localparam int S  = W - 1;
    localparam int NW = W + FRAC_BITS + 1;

    logic [W:0]   r_rem [0:S-1];
    logic [W-1:0] r_num [0:S-1];
    logic [W-1:0] r_den [0:S-1];
    logic [W-2:0] r_q   [0:S];
    logic [NW-1:0] init_sh;

    // quotient fits W-1 bits unless saturated, so start from the dividend shifted down by W-1 bits
    assign init_sh = {1'b0, i_num, {FRAC_BITS{1'b0}}} >> (W - 1);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= init_sh[W:0];
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
    end

    for (genvar k = 1; k <= S; k++) begin : g_step
        localparam int B = W - 1 - k;
        logic       nb, ge;
        logic [W:0] rem_sh;
        if (B >= FRAC_BITS) begin : g_bit
            assign nb = r_num[k-1][B-FRAC_BITS];
        end else begin : g_zero
            assign nb = 1'b0;
        end
        assign rem_sh = {r_rem[k-1][W-1:0], nb};
        assign ge     = rem_sh >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            r_q[k] <= {r_q[k-1][W-3:0], ge};
        end
        if (k < S) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= ge ? (rem_sh - {1'b0, r_den[k-1]}) : rem_sh;
                r_num[k] <= r_num[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_q[S];
endmodule
`default_nettype wire

FILE: rtl/rbi_back.sv
// Back end: plane distances, hit plane choice, off-plane check and result register.
`default_nettype none
module rbi_back
    import rbi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  t_ctrl                       i_ctrl,
    input  logic [2:0][COORD_WIDTH-1:0] i_o,
    input  logic [2:0][COORD_WIDTH-1:0] i_lo,
    input  logic [2:0][COORD_WIDTH-1:0] i_hi,
    input  logic [2:0][COORD_WIDTH-1:0] i_dmag,
    input  logic [2:0][COORD_WIDTH-1:0] i_nmag,
    output logic                        o_valid,
    output logic                        o_is_hit,
    output logic [2:0][COORD_WIDTH-1:0] o_hit
);
    localparam int W  = COORD_WIDTH;
    localparam int S  = W - 1;
    localparam int PW = 2 * W;
    localparam int EW = 2 * W + 2;
    localparam logic [W-1:0] LIM = {1'b0, {(W - 1){1'b1}}};

    // payload alongside the dividers
    logic              r_vld  [0:S];
    t_ctrl             r_ctrl [0:S];
    logic [2:0][W-1:0] r_o    [0:S];
    logic [2:0][W-1:0] r_lo   [0:S];
    logic [2:0][W-1:0] r_hi   [0:S];
    logic [2:0][W-1:0] r_dmag [0:S];

    logic [2:0][W-2:0] quo;
    logic [2:0][W-1:0] tm;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_div
        rbi_div #(.COORD_WIDTH(W)) u_div (
            .i_clk (i_clk),
            .i_num (i_nmag[g]),
            .i_den (i_dmag[g]),
            .o_quo (quo[g])
        );
        assign tm[g] = !r_ctrl[S].ok[g] ? '0 :
                       r_ctrl[S].over[g] ? LIM : {1'b0, quo[g]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= S; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= S; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl[0] <= i_ctrl;
        r_o[0]    <= i_o;
        r_lo[0]   <= i_lo;
        r_hi[0]   <= i_hi;
        r_dmag[0] <= i_dmag;
        for (int k = 1; k <= S; k++) begin
            r_ctrl[k] <= r_ctrl[k-1];
            r_o[k]    <= r_o[k-1];
            r_lo[k]   <= r_lo[k-1];
            r_hi[k]   <= r_hi[k-1];
            r_dmag[k] <= r_dmag[k-1];
        end
    end

    // largest distance, lowest axis on a tie
    logic         n_found;
    logic [1:0]   n_best;
    logic [W-1:0] n_tb;

    always_comb begin
        n_found = 1'b0;
        n_best  = AXIS_X;
        n_tb    = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (r_ctrl[S].ok[i] && (!n_found || tm[i] > n_tb)) begin
                n_found = 1'b1;
                n_best  = 2'(i);
                n_tb    = tm[i];
            end
        end
    end

    logic              r_s_vld, r_s_found;
    logic [1:0]        r_s_best;
    logic [W-1:0]      r_s_tm;
    t_ctrl             r_s_ctrl;
    logic [2:0][W-1:0] r_s_o, r_s_lo, r_s_hi, r_s_dmag;

    logic              r_m_vld, r_m_found;
    logic [1:0]        r_m_best;
    t_ctrl             r_m_ctrl;
    logic [2:0][W-1:0] r_m_o, r_m_lo, r_m_hi;
    logic [2:0][PW-1:0] r_m_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_m_vld <= 1'b0;
        end else begin
            r_s_vld <= r_vld[S];
            r_m_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_found <= n_found;
        r_s_best  <= n_best;
        r_s_tm    <= n_tb;
        r_s_ctrl  <= r_ctrl[S];
        r_s_o     <= r_o[S];
        r_s_lo    <= r_lo[S];
        r_s_hi    <= r_hi[S];
        r_s_dmag  <= r_dmag[S];

        r_m_found <= r_s_found;
        r_m_best  <= r_s_best;
        r_m_ctrl  <= r_s_ctrl;
        r_m_o     <= r_s_o;
        r_m_lo    <= r_s_lo;
        r_m_hi    <= r_s_hi;
        for (int i = 0; i < NUM_AXES; i++) begin
            r_m_prod[i] <= PW'(r_s_tm) * PW'(r_s_dmag[i]);
        end
    end

    // off-plane check at full precision
    logic [2:0]        fail;
    logic [2:0][W-1:0] pt;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_chk
        logic [PW-FRAC_BITS-1:0] m;
        logic [EW-1:0] mext, v, oe, le, he, dlo, dhi;
        assign m    = r_m_prod[g][PW-1:FRAC_BITS];
        assign mext = {{(FRAC_BITS + 2){1'b0}}, m};
        assign v    = r_m_ctrl.dneg[g] ? (~mext + 1'b1) : mext;
        assign oe   = {{(EW - W){r_m_o[g][W-1]}}, r_m_o[g]};
        assign le   = {{(EW - W){r_m_lo[g][W-1]}}, r_m_lo[g]};
        assign he   = {{(EW - W){r_m_hi[g][W-1]}}, r_m_hi[g]};
        assign dlo  = le - oe;
        assign dhi  = he - oe;
        assign fail[g] = (r_m_best != 2'(g))
                         && (($signed(v) < $signed(dlo)) || ($signed(v) > $signed(dhi)));
        assign pt[g] = (r_m_best == 2'(g))
                       ? (r_m_ctrl.below[g] ? r_m_lo[g] : r_m_hi[g])
                       : (r_m_o[g] + v[W-1:0]);
    end

    logic              n_hit;
    logic [2:0][W-1:0] n_pt;
    logic              r_valid, r_is_hit;
    logic [2:0][W-1:0] r_hit;

    always_comb begin
        n_hit = r_m_ctrl.in_box || (r_m_found && !(|fail));
        if (r_m_ctrl.in_box) n_pt = r_m_o;
        else if (n_hit)      n_pt = pt;
        else                 n_pt = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_hit <= n_hit;
        r_hit    <= n_pt;
    end

    assign o_valid  = r_valid;
    assign o_is_hit = r_is_hit;
    assign o_hit    = r_hit;
endmodule
`default_nettype wire

FILE: rtl/ray_box_intersection_unit.sv
// Ray versus axis-aligned box intersection unit, signed fixed point.
// The distance dividers are bit-per-stage pipelines with COORD_WIDTH-1 quotient-bit stages.
// Throughput: one test per cycle; busy stays low as the back end drains every cycle.
// Reset: synchronous, active low; clears the queue and every valid flag.
// Results are a single-cycle strobe; the receiver cannot stall.
`default_nettype none
module ray_box_intersection_unit
    import rbi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_heading_x,
    input  logic signed [COORD_WIDTH-1:0] i_heading_y,
    input  logic signed [COORD_WIDTH-1:0] i_heading_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_lo_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_hi_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_hi_z,
    output logic                          o_valid,
    output logic                          o_is_hit,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y,
    output logic signed [COORD_WIDTH-1:0] o_hit_z
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = CTRL_WIDTH + 15 * W;

    logic [2:0][W-1:0] in_o, in_h, in_lo, in_hi;
    logic              take;

    // front end outputs
    logic              f_valid;
    t_ctrl             f_ctrl;
    logic [2:0][W-1:0] f_o, f_lo, f_hi, f_dmag, f_nmag;

    // queue head
    logic              q_valid, q_full;
    logic [DW-1:0]     q_data;
    t_ctrl             b_ctrl;
    logic [2:0][W-1:0] b_o, b_lo, b_hi, b_dmag, b_nmag;

    logic [2:0][W-1:0] hit;

    assign in_o  = {i_origin_z, i_origin_y, i_origin_x};
    assign in_h  = {i_heading_z, i_heading_y, i_heading_x};
    assign in_lo = {i_box_lo_z, i_box_lo_y, i_box_lo_x};
    assign in_hi = {i_box_hi_z, i_box_hi_y, i_box_hi_x};

    // a beat is taken on start while the queue has room
    assign take = start && !busy;
    assign busy = q_full;

    rbi_front #(.COORD_WIDTH(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_o     (in_o),
        .i_h     (in_h),
        .i_lo    (in_lo),
        .i_hi    (in_hi),
        .o_valid (f_valid),
        .o_ctrl  (f_ctrl),
        .o_o     (f_o),
        .o_lo    (f_lo),
        .o_hi    (f_hi),
        .o_dmag  (f_dmag),
        .o_nmag  (f_nmag)
    );

    rbi_queue #(.DATA_WIDTH(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_ctrl, f_o, f_lo, f_hi, f_dmag, f_nmag}),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    // back end is fully pipelined, so the head is popped every cycle it is valid
    assign {b_ctrl, b_o, b_lo, b_hi, b_dmag, b_nmag} = q_data;

    rbi_back #(.COORD_WIDTH(W)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_ctrl   (b_ctrl),
        .i_o      (b_o),
        .i_lo     (b_lo),
        .i_hi     (b_hi),
        .i_dmag   (b_dmag),
        .i_nmag   (b_nmag),
        .o_valid  (o_valid),
        .o_is_hit (o_is_hit),
        .o_hit    (hit)
    );

    assign o_hit_x = hit[0];
    assign o_hit_y = hit[1];
    assign o_hit_z = hit[2];
endmodule
`default_nettype wire

FILE: rtl/rbi_checker.sv
// Port-level checks for the ray/box intersection unit, bound to the top level.
`default_nettype none
module rbi_checker
    import rbi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_valid,
    input logic                   o_is_hit,
    input logic [COORD_WIDTH-1:0] o_hit_x,
    input logic [COORD_WIDTH-1:0] o_hit_y,
    input logic [COORD_WIDTH-1:0] o_hit_z
);
    localparam int LAT = COORD_WIDTH + 5;

    // every result strobe traces back to an accepted beat a fixed time earlier
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching accepted beat");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_hit) |-> (o_hit_x == '0 && o_hit_y == '0 && o_hit_z == '0))
        else $error("miss with non-zero hit point");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised on a free-running pipeline");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("strobe after reset");

endmodule

bind ray_box_intersection_unit rbi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_is_hit (o_is_hit),
    .o_hit_x  (o_hit_x),
    .o_hit_y  (o_hit_y),
    .o_hit_z  (o_hit_z)
);
`default_nettype wire
